// File: hw/rtl/rle_row_delta_bitmap_decoder_macros.svh
// Assertion macros shared by the row-delta bitmap decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RLE_ROW_DELTA_BITMAP_DECODER_MACROS_SVH
`define RLE_ROW_DELTA_BITMAP_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define RLRD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rlrd: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define RLRD_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rlrd: next-cycle check failed");

`endif

// File: hw/rtl/rlrd_pkg.sv
// Shared types and constants of the row-delta bitmap decoder.
// Depends on nothing; imported by every module of the block.
package rlrd_pkg;

    localparam int BYTE_W            = 8;
    localparam int WORD_W            = 16;
    localparam int COORD_W           = 15;
    localparam int ROW_WIDTH_W       = 11;
    localparam int ROWS_W            = 15;
    localparam int RUN_CNT_W         = 7;
    localparam int OUT_W             = 16;
    localparam int MAX_ROW_WORDS_DEF = 64;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 11'd800;
    localparam logic [ROWS_W-1:0]      ROW_COUNT_RST = 15'd1;

    typedef enum logic [1:0] {
        REG_ORIGIN_X  = 2'd0,
        REG_ORIGIN_Y  = 2'd1,
        REG_ROW_WIDTH = 2'd2,
        REG_ROW_COUNT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_READ,
        SQ_EMIT
    } seq_state_t;

    typedef enum logic [2:0] {
        PH_CTRL    = 3'd0,
        PH_REP_HI  = 3'd1,
        PH_REP_LO  = 3'd2,
        PH_LIT_HI  = 3'd3,
        PH_LIT_LO  = 3'd4,
        PH_SKIP_HI = 3'd5,
        PH_SKIP_LO = 3'd6
    } parse_phase_t;

    typedef struct packed {
        logic [COORD_W-1:0]     origin_x;
        logic [COORD_W-1:0]     origin_y;
        logic [ROW_WIDTH_W-1:0] row_width;
        logic [ROWS_W-1:0]      row_count;
    } cfg_t;

    typedef struct packed {
        logic [OUT_W-1:0]  row_y;
        logic [OUT_W-1:0]  first_pixel_x;
        logic [WORD_W-1:0] pixel_word;
        logic              end_of_row;
        logic              end_of_image;
        logic              run_clipped;
        logic              last_of_run;
    } result_t;

endpackage

// File: hw/rtl/rlrd_row_mem.sv
// Previous-row word store: one write port, one read port, registered read data.
// Depends on rlrd_pkg.
module rlrd_row_mem
    import rlrd_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
    parameter int ADDR_W        = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] store_mem [MAX_ROW_WORDS];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rlrd_seq.sv
// Byte parser and word sequencer: read, XOR and write back the row store.
// Depends on rlrd_pkg, rlrd_row_mem (via ports) and the assertion macros.
`include "rle_row_delta_bitmap_decoder_macros.svh"

module rlrd_seq
    import rlrd_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF,
    parameter int ADDR_W        = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  cfg_t              cfg,
    input  logic              out_ready,
    output logic              res_valid,
    output result_t           res,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [WORD_W-1:0] rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [WORD_W-1:0] wr_data
);

    localparam int COL_W   = $clog2(MAX_ROW_WORDS + 1);
    localparam int MAX_PIX = 16 * MAX_ROW_WORDS;
    localparam int EW_W    = $clog2(MAX_PIX + 1);
    localparam int WD_W    = (EW_W > ROW_WIDTH_W) ? EW_W : ROW_WIDTH_W;
    localparam int CNT_W   = (COL_W > RUN_CNT_W) ? COL_W : RUN_CNT_W;

    seq_state_t             state_reg, state_next;
    parse_phase_t           phase_reg, phase_next;
    logic [BYTE_W-1:0]      held_reg, held_next;
    logic [RUN_CNT_W-1:0]   words_left_reg, words_left_next;
    logic [RUN_CNT_W-1:0]   run_cnt_reg, run_cnt_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROWS_W-1:0]      row_reg, row_next;
    logic                   image_done_reg, image_done_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic                   clip_reg, clip_next;

    logic [WD_W-1:0]        w_ext;
    logic [WD_W-1:0]        ew;
    logic [WD_W:0]          rw_sum;
    logic [COL_W-1:0]       rw;
    logic [COL_W:0]         col_inc;
    logic [COL_W-1:0]       slots;
    logic [CNT_W-1:0]       wl_ext;
    logic [CNT_W-1:0]       slots_ext;
    logic                   clip_now;
    logic                   last;
    logic [ROWS_W-1:0]      rc;
    logic                   eoi;
    logic [RUN_CNT_W-1:0]   wl_dec;
    logic [WORD_W-1:0]      prev;
    logic [WORD_W-1:0]      cur;
    logic [WORD_W-1:0]      pix;
    logic                   work;

    // Row geometry from the live configuration.
    always_comb
    begin
        w_ext = WD_W'(cfg.row_width);
        if (w_ext == '0)
        begin
            ew = WD_W'(1);
        end
        else if (w_ext > WD_W'(MAX_PIX))
        begin
            ew = WD_W'(MAX_PIX);
        end
        else
        begin
            ew = w_ext;
        end
        rw_sum    = {1'b0, ew} + (WD_W + 1)'(15);
        rw        = COL_W'(rw_sum >> 4);
        col_inc   = {1'b0, col_reg} + (COL_W + 1)'(1);
        last      = (col_inc >= {1'b0, rw});
        slots     = (col_reg < rw) ? (rw - col_reg) : COL_W'(1);
        wl_ext    = CNT_W'(words_left_reg);
        slots_ext = CNT_W'(slots);
        clip_now  = (wl_ext > slots_ext);
        rc        = (cfg.row_count == '0) ? ROWS_W'(1) : cfg.row_count;
        eoi       = last && (({1'b0, row_reg} + (ROWS_W + 1)'(1)) >= {1'b0, rc});
        wl_dec    = words_left_reg - RUN_CNT_W'(1);
    end

    // XOR with the stored word of the previous row; the first row sees zeros.
    always_comb
    begin
        prev = (row_reg != '0) ? rd_data : '0;
        cur  = word_reg ^ prev;
        if (last && (ew[3:0] != 4'd0))
        begin
            pix = cur & ~(16'hFFFF >> ew[3:0]);
        end
        else
        begin
            pix = cur;
        end
    end

    assign in_ready = (state_reg == SQ_IDLE);
    assign work     = in_valid && in_ready && !image_done_reg;
    assign rd_addr  = col_reg[ADDR_W-1:0];
    assign wr_addr  = col_reg[ADDR_W-1:0];
    assign wr_data  = cur;

    always_comb
    begin
        res.row_y         = OUT_W'(cfg.origin_y) + OUT_W'(row_reg);
        res.first_pixel_x = OUT_W'(cfg.origin_x) + OUT_W'({col_reg, 4'b0000});
        res.pixel_word    = pix;
        res.end_of_row    = last;
        res.end_of_image  = eoi;
        res.run_clipped   = clip_reg;
        res.last_of_run   = (run_cnt_reg == RUN_CNT_W'(1)) || eoi;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        words_left_next = words_left_reg;
        run_cnt_next    = run_cnt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        image_done_next = image_done_reg;
        word_next       = word_reg;
        clip_next       = clip_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            SQ_IDLE:
            begin
                if (work)
                begin
                    case (phase_reg)
                        PH_CTRL:
                        begin
                            words_left_next = in_byte[RUN_CNT_W-1:0];
                            if (in_byte[RUN_CNT_W-1:0] == '0)
                            begin
                                phase_next = PH_CTRL;
                            end
                            else if (in_byte[BYTE_W-1])
                            begin
                                phase_next = PH_REP_HI;
                            end
                            else
                            begin
                                phase_next = PH_LIT_HI;
                            end
                        end
                        PH_REP_HI:
                        begin
                            held_next  = in_byte;
                            phase_next = PH_REP_LO;
                        end
                        PH_REP_LO:
                        begin
                            // Clip the run at the row end.
                            word_next       = {held_reg, in_byte};
                            clip_next       = clip_now;
                            run_cnt_next    = clip_now ? RUN_CNT_W'(slots_ext)
                                                       : words_left_reg;
                            words_left_next = '0;
                            phase_next      = PH_CTRL;
                            rd_en           = 1'b1;
                            state_next      = SQ_EMIT;
                        end
                        PH_LIT_HI:
                        begin
                            held_next  = in_byte;
                            phase_next = PH_LIT_LO;
                        end
                        PH_LIT_LO:
                        begin
                            word_next       = {held_reg, in_byte};
                            clip_next       = clip_now;
                            run_cnt_next    = RUN_CNT_W'(1);
                            words_left_next = wl_dec;
                            if (wl_dec == '0)
                            begin
                                phase_next = PH_CTRL;
                            end
                            else if (last)
                            begin
                                phase_next = PH_SKIP_HI;
                            end
                            else
                            begin
                                phase_next = PH_LIT_HI;
                            end
                            rd_en      = 1'b1;
                            state_next = SQ_EMIT;
                        end
                        PH_SKIP_HI:
                        begin
                            held_next  = in_byte;
                            phase_next = PH_SKIP_LO;
                        end
                        PH_SKIP_LO:
                        begin
                            words_left_next = wl_dec;
                            phase_next      = (wl_dec == '0) ? PH_CTRL : PH_SKIP_HI;
                        end
                        default:
                        begin
                            phase_next = PH_CTRL;
                        end
                    endcase
                end
            end
            SQ_READ:
            begin
                rd_en      = 1'b1;
                state_next = SQ_EMIT;
            end
            SQ_EMIT:
            begin
                if (out_ready)
                begin
                    res_valid    = 1'b1;
                    wr_en        = 1'b1;
                    run_cnt_next = run_cnt_reg - RUN_CNT_W'(1);
                    if (last)
                    begin
                        col_next = '0;
                        if (eoi)
                        begin
                            image_done_next = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + ROWS_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = COL_W'(col_inc);
                    end
                    if ((run_cnt_reg == RUN_CNT_W'(1)) || eoi)
                    begin
                        state_next = SQ_IDLE;
                    end
                    else
                    begin
                        state_next = SQ_READ;
                    end
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= SQ_IDLE;
            phase_reg      <= PH_CTRL;
            held_reg       <= '0;
            words_left_reg <= '0;
            run_cnt_reg    <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            image_done_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            held_reg       <= held_next;
            words_left_reg <= words_left_next;
            run_cnt_reg    <= run_cnt_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            image_done_reg <= image_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        clip_reg <= clip_next;
    end

    `RLRD_ASSERT_NXT(a_done_after_eoi, clk, rst_n, res_valid && res.end_of_image, image_done_reg)
    `RLRD_ASSERT_IMP(a_quiet_when_done, clk, rst_n, image_done_reg, !res_valid)
    `RLRD_ASSERT_IMP(a_run_live, clk, rst_n, state_reg != SQ_IDLE, run_cnt_reg != '0)
    `RLRD_ASSERT_IMP(a_col_in_store, clk, rst_n, 1'b1, col_reg < COL_W'(MAX_ROW_WORDS))

endmodule

// File: hw/rtl/rle_row_delta_bitmap_decoder.sv
// Top level of the run-length bitmap decoder with row-to-row XOR delta.
// Depends on rlrd_pkg, rlrd_row_mem and rlrd_seq.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-----------------------------------
//  s_*       | in  | s_tvalid / s_tready    | s_tdata: compressed stream byte
//  m_*       | out | m_tvalid / m_tready    | m_tdata, m_tuser flags, m_tlast
//  APB       | in  | psel & penable, pready | four config registers at 4*i
//
// Control bytes, data high bytes and dropped bytes are each taken in the idle state.
// Each decoded word is a row store read (registered read data), then the emit
// step for the XOR, write-back and output load, which waits on the output
// register; s_tready stays low until the words a byte produced are emitted.
// Reset clears the parser, row/column counters and image-done flag at once;
// the row store needs no clearing pass, since row 0 ignores its contents.
// A full output register with m_tready low holds the sequencer in its emit step.
module rle_row_delta_bitmap_decoder
    import rlrd_pkg::*;
#(
    parameter int MAX_ROW_WORDS = MAX_ROW_WORDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] row_y, [31:16] first_pixel_x, [47:32] pixel_word
    output logic [2:0]  m_tuser,   // [0] end_of_row, [1] end_of_image, [2] run_clipped
    output logic        m_tlast,   // last_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int ADDR_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

    cfg_t              cfg_reg;
    reg_idx_t          reg_idx;
    logic              cfg_write;

    result_t           res;
    logic              res_valid;
    result_t           out_reg;
    logic              out_valid_reg;
    logic              out_ready;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;

    // Register file: word index from paddr, write on the access phase.
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x  <= '0;
            cfg_reg.origin_y  <= '0;
            cfg_reg.row_width <= ROW_WIDTH_RST;
            cfg_reg.row_count <= ROW_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_ORIGIN_X:  cfg_reg.origin_x  <= pwdata[COORD_W-1:0];
                REG_ORIGIN_Y:  cfg_reg.origin_y  <= pwdata[COORD_W-1:0];
                REG_ROW_WIDTH: cfg_reg.row_width <= pwdata[ROW_WIDTH_W-1:0];
                REG_ROW_COUNT: cfg_reg.row_count <= pwdata[ROWS_W-1:0];
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ORIGIN_X:  prdata = 32'(cfg_reg.origin_x);
            REG_ORIGIN_Y:  prdata = 32'(cfg_reg.origin_y);
            REG_ROW_WIDTH: prdata = 32'(cfg_reg.row_width);
            REG_ROW_COUNT: prdata = 32'(cfg_reg.row_count);
            default:       prdata = '0;
        endcase
    end

    rlrd_row_mem #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .ADDR_W        (ADDR_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Reads and write-backs of the store never fall in the same cycle: each
    // write lands at the emit edge, before the next read is issued.
    rlrd_seq #(
        .MAX_ROW_WORDS (MAX_ROW_WORDS),
        .ADDR_W        (ADDR_W)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cfg       (cfg_reg),
        .out_ready (out_ready),
        .res_valid (res_valid),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Output register: load a new result when empty or when the current
    // transfer completes; hold otherwise.
    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.pixel_word, out_reg.first_pixel_x, out_reg.row_y};
    assign m_tuser  = {out_reg.run_clipped, out_reg.end_of_image, out_reg.end_of_row};
    assign m_tlast  = out_reg.last_of_run;

endmodule

// File: bench/rlrd_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the row-delta bitmap decoder: mirrors the decoding of the byte
// stream, predicts every output word and compares each m_* transfer with it.
// Depends on rlrd_pkg; instantiated beside the block by the testbench top.
module rlrd_decode_checker
    import rlrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          words_pending,
    output logic        image_ended
);

    localparam int STORE_DEPTH  = MAX_ROW_WORDS_DEF;
    localparam int REPORT_LIMIT = 10;

    logic [COORD_W-1:0]     x_base;
    logic [COORD_W-1:0]     y_base;
    logic [ROW_WIDTH_W-1:0] width_px;
    logic [ROWS_W-1:0]      rows_total;

    logic [WORD_W-1:0]      row_above [STORE_DEPTH];
    logic [ROWS_W-1:0]      cur_row;
    logic [RUN_CNT_W-1:0]   cur_col;
    parse_phase_t           parse_state;
    logic [BYTE_W-1:0]      held_hi;
    logic [RUN_CNT_W-1:0]   words_to_go;

    result_t                expected_words [$];

    function automatic int visible_width();
        int w;
        w = int'(width_px);
        if (w == 0) w = 1;
        if (w > 16 * STORE_DEPTH) w = 16 * STORE_DEPTH;
        return w;
    endfunction

    function automatic int words_per_row();
        return (visible_width() + 15) / 16;
    endfunction

    // A column already past a shrunken row end still gets one slot.
    function automatic int cols_remaining();
        int rw;
        rw = words_per_row();
        return (int'(cur_col) < rw) ? rw - int'(cur_col) : 1;
    endfunction

    // Queue one decoded word; returns 1 when it closes its row.
    function automatic bit put_word(logic [WORD_W-1:0] raw, bit clipped);
        int                rw;
        int                c;
        int                rc;
        int                vb;
        int                px;
        logic [WORD_W-1:0] above;
        logic [WORD_W-1:0] cur;
        bit                row_end;
        result_t           w;
        rw    = words_per_row();
        c     = int'(cur_col);
        rc    = (rows_total == '0) ? 1 : int'(rows_total);
        above = '0;
        if (cur_row != '0 && c < STORE_DEPTH) above = row_above[c];
        cur = raw ^ above;
        if (c < STORE_DEPTH) row_above[c] = cur;

        row_end      = (c + 1 >= rw);
        w.pixel_word = cur;
        if (row_end) begin
            vb = visible_width() - 16 * (rw - 1);
            if (vb < 16) w.pixel_word = cur & ~(16'hFFFF >> vb);
        end
        px              = int'(y_base) + int'(cur_row);
        w.row_y         = px[15:0];
        px              = int'(x_base) + 16 * c;
        w.first_pixel_x = px[15:0];
        w.end_of_row    = row_end;
        w.end_of_image  = row_end && (int'(cur_row) + 1 >= rc);
        w.run_clipped   = clipped;
        w.last_of_run   = 1'b0;
        expected_words.push_back(w);

        if (row_end) begin
            cur_col = '0;
            if (w.end_of_image) image_ended = 1'b1;
            else cur_row = cur_row + 1'b1;
        end else begin
            cur_col = cur_col + 1'b1;
        end
        return row_end;
    endfunction

    function automatic void decode_byte(logic [BYTE_W-1:0] b);
        int                cnt;
        int                i;
        int                count_at_entry;
        bit                clip;
        bit                row_end;
        result_t           w;
        if (image_ended) return;
        count_at_entry = expected_words.size();
        case (parse_state)
            PH_REP_HI: begin
                held_hi     = b;
                parse_state = PH_REP_LO;
            end
            PH_REP_LO: begin
                cnt  = int'(words_to_go);
                clip = cnt > cols_remaining();
                if (clip) cnt = cols_remaining();
                for (i = 0; i < cnt && !image_ended; i++) void'(put_word({held_hi, b}, clip));
                words_to_go = '0;
                parse_state = PH_CTRL;
            end
            PH_LIT_HI: begin
                held_hi     = b;
                parse_state = PH_LIT_LO;
            end
            PH_LIT_LO: begin
                clip        = int'(words_to_go) > cols_remaining();
                row_end     = put_word({held_hi, b}, clip);
                words_to_go = words_to_go - 1'b1;
                if (words_to_go == '0) parse_state = PH_CTRL;
                else parse_state = row_end ? PH_SKIP_HI : PH_LIT_HI;
            end
            PH_SKIP_HI: begin
                held_hi     = b;
                parse_state = PH_SKIP_LO;
            end
            PH_SKIP_LO: begin
                words_to_go = words_to_go - 1'b1;
                parse_state = (words_to_go != '0) ? PH_SKIP_HI : PH_CTRL;
            end
            default: begin
                words_to_go = b[RUN_CNT_W-1:0];
                if (words_to_go == '0) parse_state = PH_CTRL;
                else parse_state = b[7] ? PH_REP_HI : PH_LIT_HI;
            end
        endcase
        // Flag the last word this byte produced.
        if (expected_words.size() > count_at_entry) begin
            w             = expected_words.pop_back();
            w.last_of_run = 1'b1;
            expected_words.push_back(w);
        end
    endfunction

    function automatic void write_register(reg_idx_t idx, logic [31:0] value);
        case (idx)
            REG_ORIGIN_X:  x_base     = value[COORD_W-1:0];
            REG_ORIGIN_Y:  y_base     = value[COORD_W-1:0];
            REG_ROW_WIDTH: width_px   = value[ROW_WIDTH_W-1:0];
            REG_ROW_COUNT: rows_total = value[ROWS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic string describe(result_t w);
        return $sformatf("y=%h x=%h px=%h eor=%b eoi=%b clip=%b tlast=%b",
                         w.row_y, w.first_pixel_x, w.pixel_word, w.end_of_row,
                         w.end_of_image, w.run_clipped, w.last_of_run);
    endfunction

    function automatic void note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%t  %s", $realtime, msg);
    endfunction

    function automatic void check_word();
        result_t seen;
        result_t want;
        string   bad;
        seen.row_y         = m_tdata[15:0];
        seen.first_pixel_x = m_tdata[31:16];
        seen.pixel_word    = m_tdata[47:32];
        seen.end_of_row    = m_tuser[0];
        seen.end_of_image  = m_tuser[1];
        seen.run_clipped   = m_tuser[2];
        seen.last_of_run   = m_tlast;
        if (expected_words.size() == 0) begin
            note_failure({"output transfer with nothing expected: ", describe(seen)});
            return;
        end
        want = expected_words.pop_front();
        bad  = "";
        if (seen.row_y !== want.row_y) bad = {bad, " row_y"};
        if (seen.first_pixel_x !== want.first_pixel_x) bad = {bad, " first_pixel_x"};
        if (seen.pixel_word !== want.pixel_word) bad = {bad, " pixel_word"};
        if (seen.end_of_row !== want.end_of_row) bad = {bad, " end_of_row"};
        if (seen.end_of_image !== want.end_of_image) bad = {bad, " end_of_image"};
        if (seen.run_clipped !== want.run_clipped) bad = {bad, " run_clipped"};
        if (seen.last_of_run !== want.last_of_run) bad = {bad, " last_of_run"};
        if (bad != "")
            note_failure($sformatf("mismatch in%s: expected %s, got %s",
                                   bad, describe(want), describe(seen)));
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            x_base         = '0;
            y_base         = '0;
            width_px       = ROW_WIDTH_RST;
            rows_total     = ROW_COUNT_RST;
            cur_row        = '0;
            cur_col        = '0;
            parse_state    = PH_CTRL;
            held_hi        = '0;
            words_to_go    = '0;
            image_ended    = 1'b0;
            mismatch_count = 0;
            words_pending  = 0;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                write_register(reg_idx_t'(paddr[3:2]), pwdata);
            if (s_tvalid && s_tready) decode_byte(s_tdata);
            if (m_tvalid && m_tready) check_word();
            words_pending = expected_words.size();
        end
    end

endmodule

// File: bench/tb_rle_row_delta_bitmap_decoder.sv
`timescale 1ns / 1ps
// Testbench top for rle_row_delta_bitmap_decoder: drives the byte stream, the
// APB registers and output back-pressure, then gives the verdict.
// Depends on rlrd_pkg, the block's RTL and rlrd_decode_checker.
module tb_rle_row_delta_bitmap_decoder
    import rlrd_pkg::*;
;

    localparam real HALF_PERIOD     = 2.0;
    localparam int  RESET_CYCLES    = 6;
    // Worst case per byte: a repeat of 64 words, each behind a random receiver
    // stall; a few hundred bytes fit well below the limit.
    localparam int  CYCLE_LIMIT     = 600000;
    // Quiet cycles after the last expected word before touching registers.
    localparam int  SETTLE_CYCLES   = 12;
    localparam int  RANDOM_PHASES   = 8;
    localparam int  BYTES_PER_PHASE = 18;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [7:0] data_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;      // [15:0] row_y, [31:16] first_pixel_x, [47:32] pixel_word
    logic [2:0]  m_tuser;      // [0] end_of_row, [1] end_of_image, [2] run_clipped
    logic        m_tlast;      // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          words_pending;
    logic        image_ended;

    int          stream_bytes;
    int          cycle_count;
    bit          send_calm;
    bit          recv_calm;

    // Bytes that close the image from any parser state: a repeat of 127 words
    // when aligned, otherwise plain data words that keep filling the row.
    logic [7:0]  closing_bytes [3] = '{8'hFF, 8'h5A, 8'hA5};

    always #(HALF_PERIOD) clk = ~clk;

    rle_row_delta_bitmap_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    rlrd_decode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending),
        .image_ended    (image_ended)
    );

    // Draw the idle cycles before the next transfer; calm stretches draw none.
    function automatic int draw_wait(bit calm);
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // Offer one byte at the falling edge and hold it until the transfer.
    // With no gap drawn, tvalid simply stays high for the next byte.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        stream_bytes++;
        @(negedge clk);
    endtask

    // Setup cycle, access cycle, then idle with psel low so back-to-back writes
    // never drive psel twice in the same step.
    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Hold the stream until every predicted word has left the block, then let
    // any byte that makes no word drain out before the next register write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (words_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_origin();
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'd32767;
            default: return $urandom_range(0, 32767);
        endcase
    endfunction

    // Mostly narrow rows; the extremes, the zero and the saturating widths
    // come up regularly. The store is full after row 0, so widening is safe.
    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd16;
            3:       return 32'd17;
            4:       return 32'd1024;
            5:       return 32'd2047;
            default: return $urandom_range(1, 200);
        endcase
    endfunction

    // One run of the compressed stream: well-formed literals and repeats with
    // random content, some empty runs, and an occasional stray byte that may
    // knock the parser out of step.
    task automatic send_run();
        int kind;
        int cnt;
        int i;
        kind = $urandom_range(0, 19);
        if (kind < 9) begin
            cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            send_byte({1'b0, 7'(cnt)});
            for (i = 0; i < 2 * cnt; i++) send_byte(8'($urandom));
        end else if (kind < 16) begin
            cnt = $urandom_range(1, 127);
            send_byte({1'b1, 7'(cnt)});
            send_byte(8'($urandom));
            send_byte(8'($urandom));
        end else if (kind < 18) begin
            send_byte(($urandom_range(0, 1) == 1) ? 8'h80 : 8'h00);
        end else begin
            send_byte(8'($urandom));
        end
    endtask

    // Receiver: stall a random number of cycles before each word, with
    // calm phases where tready stays high.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = draw_wait(recv_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // Watchdog: a run that hangs ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int phase_no;
        int start;
        int fill;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;
        stream_bytes = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Far origins, a saturating width (64 words per row) and plenty of rows.
        apb_write(REG_ORIGIN_X, 32'd32767);
        apb_write(REG_ORIGIN_Y, 32'd32767);
        apb_write(REG_ROW_WIDTH, 32'd2047);
        apb_write(REG_ROW_COUNT, 32'd32767);

        // Fill all of row 0 with one repeat, which writes every store entry.
        send_byte(8'hC0);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // Empty repeat (no data word follows) and empty literal: no output.
        send_byte(8'h80);
        send_byte(8'h00);
        // Single literal word against the all-ones row above.
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        // Repeat of 127 from column 1: clipped at the row end.
        send_byte(8'hFF);
        send_byte(8'h12);
        send_byte(8'h34);

        // Two words per row, one visible pixel in the last: a literal of three
        // overshoots, so the third word is consumed and dropped.
        wait_idle();
        apb_write(REG_ROW_WIDTH, 32'd17);
        send_byte(8'h03);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h02);

        // Zero width reads as one pixel.
        wait_idle();
        apb_write(REG_ROW_WIDTH, 32'd0);
        send_byte(8'h01);
        send_byte(8'hAB);
        send_byte(8'hCD);

        // Random phases; each starts from an empty pipeline with new settings.
        for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
            wait_idle();
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 0 || $urandom_range(0, 1) == 1)
                apb_write(REG_ORIGIN_X, pick_origin());
            if (phase_no == 0 || $urandom_range(0, 1) == 1)
                apb_write(REG_ORIGIN_Y, pick_origin());
            apb_write(REG_ROW_WIDTH, pick_width());
            // Keep the row count far above any row the run can reach.
            if ($urandom_range(0, 2) == 0)
                apb_write(REG_ROW_COUNT, $urandom_range(16384, 32767));
            start = stream_bytes;
            while (stream_bytes - start < BYTES_PER_PHASE) send_run();
        end

        // Zero rows reads as one: the row in progress closes the image.
        wait_idle();
        send_calm = 1'b0;
        apb_write(REG_ROW_COUNT, 32'd0);
        fill = 0;
        while (!image_ended) begin
            send_byte(closing_bytes[fill % 3]);
            fill++;
        end
        // Bytes after the image are dropped without output.
        send_byte(8'h81);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_idle();

        if (mismatch_count == 0 && words_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
